### rtl/core/assert_macros.svh
// Assertion macros shared by the wind sensor frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define WSFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wind sensor frame parser assertion failed");
`define WSFP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("wind sensor frame parser forbidden condition seen");
`else
`define WSFP_ASSERT(lbl, clk, rst_n, prop)
`define WSFP_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

### rtl/core/wsfp_pkg.sv
// Package with types and constants of the wind sensor frame parser.
package wsfp_pkg;

  localparam logic [7:0] FRAME_ID  = 8'h01;
  localparam logic [7:0] FRAME_LEN = 8'h06;
  localparam logic [7:0] SEED_XOR  = 8'h33;

  localparam int unsigned WSFP_QUEUE_DEPTH = 2;

  localparam int unsigned SPEED_W = 19;
  localparam int unsigned DIR_W   = 18;
  localparam int unsigned OUT_TDATA_W = 40;

  // floor(2^24 / 5) * 32, speed quotient taken from bits 42:24
  localparam logic [26:0] SPD_RECIP = 27'd107374176;
  // floor(2^32 / 127) * 92160, direction quotient taken from bits 49:32
  localparam logic [41:0] DIR_RECIP = 42'd3116725862400;
  localparam logic [24:0] DIR_SCALE = 25'd92160;
  localparam logic [24:0] DIR_DIV   = 25'd127;
  localparam logic [21:0] SPD_DIV   = 22'd5;

  typedef struct packed {
    logic [7:0]  dir;
    logic [15:0] speed_raw;
  } wsfp_frame_t;

  typedef struct packed {
    logic        valid;
    wsfp_frame_t frame;
  } wsfp_push_t;

  typedef struct packed {
    logic        valid;
    wsfp_frame_t frame;
  } wsfp_head_t;

endpackage

### rtl/core/wsfp_front.sv
// Frame hunter: tracks the frame phase, checksum and captured payload bytes.
module wsfp_front
  import wsfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  output logic       byte_ready_o,
  input  logic [7:0] byte_i,
  input  logic       q_full_i,
  output wsfp_push_t push_o
);

  localparam logic [2:0] PH_ID   = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_DIR  = 3'd2;
  localparam logic [2:0] PH_TEMP = 3'd3;
  localparam logic [2:0] PH_SPDH = 3'd4;
  localparam logic [2:0] PH_SPDL = 3'd5;
  localparam logic [2:0] PH_CHK  = 3'd6;

  logic [2:0] phase_q, phase_d;
  logic [7:0] accum_q, accum_d;
  logic [7:0] dir_q, dir_d;
  logic [7:0] spdh_q, spdh_d;
  logic [7:0] spdl_q, spdl_d;
  logic       take;

  assign byte_ready_o = !q_full_i;
  assign take         = byte_valid_i && byte_ready_o;

  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    dir_d   = dir_q;
    spdh_d  = spdh_q;
    spdl_d  = spdl_q;
    push_o.valid = 1'b0;
    push_o.frame.dir = dir_q;
    push_o.frame.speed_raw = {spdh_q, spdl_q};
    if (take) begin
      case (phase_q)
        PH_LEN: begin
          if (byte_i == FRAME_LEN) begin
            accum_d = accum_q ^ byte_i;
            phase_d = PH_DIR;
          end else begin
            phase_d = PH_ID;
          end
        end
        PH_DIR: begin
          dir_d   = byte_i;
          accum_d = accum_q ^ byte_i;
          phase_d = PH_TEMP;
        end
        PH_TEMP: begin
          accum_d = accum_q ^ byte_i;
          phase_d = PH_SPDH;
        end
        PH_SPDH: begin
          spdh_d  = byte_i;
          accum_d = accum_q ^ byte_i;
          phase_d = PH_SPDL;
        end
        PH_SPDL: begin
          spdl_d  = byte_i;
          accum_d = accum_q ^ byte_i;
          phase_d = PH_CHK;
        end
        PH_CHK: begin
          push_o.valid = (byte_i == accum_q);
          phase_d = PH_ID;
        end
        default: begin
          if (byte_i == FRAME_ID) begin
            accum_d = SEED_XOR ^ FRAME_ID;
            phase_d = PH_LEN;
          end else begin
            phase_d = PH_ID;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      accum_q <= SEED_XOR ^ FRAME_ID;
      dir_q   <= '0;
      spdh_q  <= '0;
      spdl_q  <= '0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      dir_q   <= dir_d;
      spdh_q  <= spdh_d;
      spdl_q  <= spdl_d;
    end
  end

endmodule

### rtl/core/wsfp_queue.sv
// Small frame queue between the frame hunter and the scaler.
module wsfp_queue
  import wsfp_pkg::*;
#(
  parameter int unsigned Depth = WSFP_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wsfp_push_t push_i,
  output logic       full_o,
  input  logic       pop_i,
  output wsfp_head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wsfp_frame_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.frame = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/core/wsfp_back.sv
// Scaler: reciprocal multiply, quotient correction and output register.
module wsfp_back
  import wsfp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wsfp_head_t               head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SPEED_W-1:0]       out_speed_o,
  output logic [DIR_W-1:0]         out_dir_o
);

  logic              s1_valid_q;
  logic [42:0]       prod_spd_q;
  logic [49:0]       prod_dir_q;
  logic [15:0]       raw_q;
  logic [7:0]        dir_q;
  logic              out_valid_q;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic [DIR_W-1:0]  wdir_q, wdir_d;
  logic              out_en;
  logic              s1_en;
  logic [SPEED_W-1:0] spd_q0;
  logic [21:0]       spd_x;
  logic [21:0]       spd_rem;
  logic [DIR_W-1:0]  dir_q0;
  logic [24:0]       dir_y;
  logic [24:0]       dir_rem;

  assign out_en = !out_valid_q || out_ready_i;
  assign s1_en  = !s1_valid_q || out_en;
  assign pop_o  = head_i.valid && s1_en;

  always_comb begin
    spd_q0  = prod_spd_q[42:24];
    spd_x   = {1'b0, raw_q, 5'b0};
    spd_rem = spd_x - (22'(spd_q0) * SPD_DIV);
    speed_d = spd_q0 + SPEED_W'(spd_rem >= SPD_DIV);
    dir_q0  = prod_dir_q[49:32];
    dir_y   = 25'(dir_q) * DIR_SCALE;
    dir_rem = dir_y - (25'(dir_q0) * DIR_DIV);
    wdir_d  = dir_q0 + DIR_W'(dir_rem >= DIR_DIV);
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      prod_spd_q <= 43'(head_i.frame.speed_raw) * 43'(SPD_RECIP);
      prod_dir_q <= 50'(head_i.frame.dir) * 50'(DIR_RECIP);
      raw_q      <= head_i.frame.speed_raw;
      dir_q      <= head_i.frame.dir;
    end
    if (out_en) begin
      speed_q <= speed_d;
      wdir_q  <= wdir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= head_i.valid;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_speed_o = speed_q;
  assign out_dir_o   = wdir_q;

endmodule

### rtl/core/wind_sensor_frame_parser.sv
// Top level of the wind sensor frame parser.
`include "assert_macros.svh"

// Takes one received byte per cycle on the slave stream whenever the frame
// queue has room, so a sender streaming bytes back to back is never slowed
// by a steady result consumer. A frame is id 0x01, length 0x06, direction,
// temperature (ignored), speed high, speed low, checksum (0x33 XOR the first
// six bytes); a frame with a good checksum yields one word on the master
// stream via the frame queue, product register and output register, holding
// the speed in 1/256 m/s and the direction in 1/256 degree. Bad frames give
// no word. The input stalls only while the frame queue is full, which
// happens only after the result consumer has held off for several frames.
module wind_sensor_frame_parser
  import wsfp_pkg::*;
#(
  parameter int unsigned QueueDepth = WSFP_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,  // [7:0] rx_byte
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // [18:0] wind_speed, [36:19] wind_direction
);

  wsfp_push_t         push;
  wsfp_head_t         head;
  logic               q_full;
  logic               pop;
  logic [SPEED_W-1:0] speed;
  logic [DIR_W-1:0]   wdir;

  wsfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .q_full_i     (q_full),
    .push_o       (push)
  );

  wsfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  wsfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_speed_o (speed),
    .out_dir_o   (wdir)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - SPEED_W - DIR_W)'(0), wdir, speed};

  `WSFP_ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, push.valid && q_full)
  `WSFP_ASSERT(a_dir_range, clk_i, rst_ni, m_axis_tvalid_o |-> (wdir <= 18'd185045))
  `WSFP_ASSERT(a_speed_range, clk_i, rst_ni, m_axis_tvalid_o |-> (speed <= 19'd419424))

endmodule
